>>> rtl/srfr_pkg.sv
package srfr_pkg;

  localparam int MAX_BEAMS_DEF = 4096;

  localparam int CFG_W    = 16;
  localparam int RANGE_W  = 16;
  localparam int ANG_W    = 16;
  localparam int OUT_W    = 17;
  localparam int CFG_IDX_W = 3;

  localparam int CORD_W     = 27;
  localparam int CORD_ITERS = 16;
  localparam int IT_W       = $clog2(CORD_ITERS);
  localparam int Z_W        = 17;

  localparam int MUL_W  = 28;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 44;
  localparam int TX_W   = 28;

  localparam int ROOT_W   = 28;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int REM_W    = 32;
  localparam int SQ_STEPS = ROOT_W / 2;
  localparam int SQ_CNT_W = $clog2(SQ_STEPS);

  localparam int INV_GAIN  = 39797;
  localparam int GAIN_SHR  = 16;
  localparam int ROT_SHR   = 14;
  localparam int SHIFT_SCL = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_ANGLE = 3'd0,
    CFG_ANGLE_STEP  = 3'd1,
    CFG_ROT_XX      = 3'd2,
    CFG_ROT_XY      = 3'd3,
    CFG_ROT_YX      = 3'd4,
    CFG_ROT_YY      = 3'd5,
    CFG_SHIFT_X     = 3'd6,
    CFG_SHIFT_Y     = 3'd7
  } cfg_idx_t;

  // Arctangent of 2^-i in units of 2^-16 turn.
  function automatic logic [Z_W-1:0] atan_turn(input logic [IT_W-1:0] i);
    logic [Z_W-1:0] r;
    case (i)
      4'd0:  r = Z_W'(8192);
      4'd1:  r = Z_W'(4836);
      4'd2:  r = Z_W'(2555);
      4'd3:  r = Z_W'(1297);
      4'd4:  r = Z_W'(651);
      4'd5:  r = Z_W'(326);
      4'd6:  r = Z_W'(163);
      4'd7:  r = Z_W'(81);
      4'd8:  r = Z_W'(41);
      4'd9:  r = Z_W'(20);
      4'd10: r = Z_W'(10);
      4'd11: r = Z_W'(5);
      4'd12: r = Z_W'(3);
      4'd13: r = Z_W'(1);
      4'd14: r = Z_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/srfr_mul.sv
module srfr_mul (
  input  logic                              clk,
  input  logic signed [srfr_pkg::MUL_W-1:0]  a,
  input  logic signed [srfr_pkg::MUL_W-1:0]  b,
  output logic signed [srfr_pkg::PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> rtl/srfr_cordic.sv
module srfr_cordic (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic [srfr_pkg::RANGE_W-1:0]        range_in,
  input  logic [srfr_pkg::ANG_W-1:0]          angle,
  output logic signed [srfr_pkg::CORD_W-1:0]  x,
  output logic signed [srfr_pkg::CORD_W-1:0]  y,
  output logic [1:0]                          quad,
  output logic                                done
);

  logic                              busy;
  logic [srfr_pkg::IT_W-1:0]         it;
  logic signed [srfr_pkg::Z_W-1:0]   z;
  logic [srfr_pkg::ANG_W-1:0]        shifted;
  logic [srfr_pkg::Z_W-1:0]          z_init;
  logic signed [srfr_pkg::CORD_W-1:0] dx;
  logic signed [srfr_pkg::CORD_W-1:0] dy;
  logic [srfr_pkg::Z_W-1:0]          at;
  logic                              dir;

  always_comb begin
    shifted = angle + srfr_pkg::ANG_W'(8192);
    z_init  = srfr_pkg::Z_W'(shifted[13:0]) - srfr_pkg::Z_W'(8192);
    dx      = y >>> it;
    dy      = x >>> it;
    at      = srfr_pkg::atan_turn(it);
    dir     = ~z[srfr_pkg::Z_W-1];
    done    = busy && (it == srfr_pkg::IT_W'(srfr_pkg::CORD_ITERS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      it   <= '0;
    end else if (start) begin
      busy <= 1'b1;
      it   <= '0;
    end else if (busy) begin
      it <= it + 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= {3'b000, range_in, 8'h00};
      y    <= '0;
      z    <= z_init;
      quad <= shifted[15:14];
    end else if (busy) begin
      if (dir) begin
        x <= x - dx;
        y <= y + dy;
        z <= z - $signed(at);
      end else begin
        x <= x + dx;
        y <= y - dy;
        z <= z + $signed(at);
      end
    end
  end

endmodule

>>> rtl/srfr_sqrt.sv
module srfr_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [srfr_pkg::RAD_W-1:0]   radicand,
  output logic [srfr_pkg::ROOT_W-1:0]  root,
  output logic                         done
);

  localparam int STEP_W = srfr_pkg::REM_W + srfr_pkg::ROOT_W;

  logic                            busy;
  logic [srfr_pkg::SQ_CNT_W-1:0]   cnt;
  logic [srfr_pkg::RAD_W-1:0]      rad;
  logic [srfr_pkg::REM_W-1:0]      rem;
  logic [STEP_W-1:0]               s1;
  logic [STEP_W-1:0]               s2;

  function automatic logic [STEP_W-1:0] sq_step(
    input logic [srfr_pkg::REM_W-1:0]  r_in,
    input logic [srfr_pkg::ROOT_W-1:0] q_in,
    input logic [1:0]                  pair
  );
    logic [srfr_pkg::REM_W-1:0]  r4;
    logic [srfr_pkg::REM_W-1:0]  trial;
    logic [srfr_pkg::REM_W-1:0]  r_out;
    logic [srfr_pkg::ROOT_W-1:0] q_out;
    r4    = {r_in[srfr_pkg::REM_W-3:0], pair};
    trial = srfr_pkg::REM_W'({q_in, 2'b01});
    if (r4 >= trial) begin
      r_out = r4 - trial;
      q_out = {q_in[srfr_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      r_out = r4;
      q_out = {q_in[srfr_pkg::ROOT_W-2:0], 1'b0};
    end
    return {r_out, q_out};
  endfunction

  always_comb begin
    s1   = sq_step(rem, root, rad[srfr_pkg::RAD_W-1 -: 2]);
    s2   = sq_step(s1[STEP_W-1 -: srfr_pkg::REM_W], s1[srfr_pkg::ROOT_W-1:0],
                   rad[srfr_pkg::RAD_W-3 -: 2]);
    done = busy && (cnt == srfr_pkg::SQ_CNT_W'(srfr_pkg::SQ_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (done) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[srfr_pkg::RAD_W-5:0], 4'h0};
      rem  <= s2[STEP_W-1 -: srfr_pkg::REM_W];
      root <= s2[srfr_pkg::ROOT_W-1:0];
    end
  end

endmodule

>>> rtl/scan_range_frame_reproject.sv
// Each range sample is turned into the distance from the configured target
// origin in these steps: the beat is taken, the beam angle is formed, 16
// CORDIC iterations run, eight products go through the single shared 28x28
// multiplier (gain correction, the rigid transform and the two squares), 14
// square-root steps run at two result bits per cycle, and the output register
// is loaded once it is free. One sample is in work at a time; a new beat is
// taken while the previous result still waits in the output register.
module scan_range_frame_reproject #(
  parameter int MAX_BEAMS = srfr_pkg::MAX_BEAMS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [srfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srfr_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [srfr_pkg::RANGE_W-1:0]      range_mm,
  input  logic                              scan_end,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [srfr_pkg::OUT_W-1:0]        frame_range,
  output logic                              scan_end_out
);

  localparam int IW = $clog2(MAX_BEAMS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ANG  = 6'b000010,
    ST_CORD = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_SQRT = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [srfr_pkg::CFG_W-1:0] start_angle;
  logic signed [srfr_pkg::CFG_W-1:0] angle_step;
  logic signed [srfr_pkg::CFG_W-1:0] rot_xx;
  logic signed [srfr_pkg::CFG_W-1:0] rot_xy;
  logic signed [srfr_pkg::CFG_W-1:0] rot_yx;
  logic signed [srfr_pkg::CFG_W-1:0] rot_yy;
  logic signed [srfr_pkg::CFG_W-1:0] shift_x;
  logic signed [srfr_pkg::CFG_W-1:0] shift_y;

  logic [IW-1:0] beam_index;
  logic          last;
  logic [2:0]    mstep;
  logic          mphase;
  logic          accept;
  logic          fin_load;

  logic [srfr_pkg::RANGE_W-1:0] range_q;

  logic signed [srfr_pkg::MUL_W-1:0]  mul_a;
  logic signed [srfr_pkg::MUL_W-1:0]  mul_b;
  logic signed [srfr_pkg::PROD_W-1:0] prod;

  logic [srfr_pkg::ANG_W-1:0]         angle;
  logic                               cord_start;
  logic signed [srfr_pkg::CORD_W-1:0] cx;
  logic signed [srfr_pkg::CORD_W-1:0] cy;
  logic [1:0]                         quad;
  logic                               cord_done;

  logic signed [srfr_pkg::CORD_W-1:0] gx;
  logic signed [srfr_pkg::CORD_W-1:0] gy;
  logic signed [srfr_pkg::CORD_W-1:0] px;
  logic signed [srfr_pkg::CORD_W-1:0] py;
  logic signed [srfr_pkg::ACC_W-1:0]  acc;
  logic signed [srfr_pkg::ACC_W-1:0]  acc_sum;
  logic signed [srfr_pkg::TX_W-1:0]   tx;
  logic signed [srfr_pkg::TX_W-1:0]   ty;
  logic signed [srfr_pkg::TX_W-1:0]   shift_term;
  logic [srfr_pkg::RAD_W-1:0]         sq;
  logic [srfr_pkg::RAD_W-1:0]         radicand;
  logic                               sq_start;
  logic [srfr_pkg::ROOT_W-1:0]        root;
  logic                               sq_done;
  logic [srfr_pkg::ROOT_W:0]          rounded;

  srfr_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  srfr_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .start    (cord_start),
    .range_in (range_q),
    .angle    (angle),
    .x        (cx),
    .y        (cy),
    .quad     (quad),
    .done     (cord_done)
  );

  srfr_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (radicand),
    .root     (root),
    .done     (sq_done)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign fin_load = (state == ST_FIN) && (!out_valid || !out_stall);

  always_comb begin
    angle      = start_angle + prod[srfr_pkg::ANG_W-1:0];
    cord_start = (state == ST_ANG);
    sq_start   = (state == ST_MUL) && mphase && (mstep == 3'd7);
    radicand   = sq + prod;
    acc_sum    = acc + prod[srfr_pkg::ACC_W-1:0];
    rounded    = {1'b0, root} + (srfr_pkg::ROOT_W + 1)'(128);

    case (quad)
      2'd1: begin
        px = -gy;
        py = gx;
      end
      2'd2: begin
        px = -gx;
        py = -gy;
      end
      2'd3: begin
        px = gy;
        py = -gx;
      end
      default: begin
        px = gx;
        py = gy;
      end
    endcase

    if (mstep[2]) begin
      shift_term = {{(srfr_pkg::TX_W - srfr_pkg::CFG_W - srfr_pkg::SHIFT_SCL)
                     {shift_y[srfr_pkg::CFG_W-1]}}, shift_y, 8'h00};
    end else begin
      shift_term = {{(srfr_pkg::TX_W - srfr_pkg::CFG_W - srfr_pkg::SHIFT_SCL)
                     {shift_x[srfr_pkg::CFG_W-1]}}, shift_x, 8'h00};
    end

    mul_a = {{(srfr_pkg::MUL_W - IW){1'b0}}, beam_index};
    mul_b = srfr_pkg::MUL_W'(angle_step);
    if ((state == ST_MUL) && !mphase) begin
      case (mstep)
        3'd0: begin
          mul_a = srfr_pkg::MUL_W'(cx);
          mul_b = srfr_pkg::MUL_W'(srfr_pkg::INV_GAIN);
        end
        3'd1: begin
          mul_a = srfr_pkg::MUL_W'(cy);
          mul_b = srfr_pkg::MUL_W'(srfr_pkg::INV_GAIN);
        end
        3'd2: begin
          mul_a = srfr_pkg::MUL_W'(rot_xx);
          mul_b = srfr_pkg::MUL_W'(px);
        end
        3'd3: begin
          mul_a = srfr_pkg::MUL_W'(rot_xy);
          mul_b = srfr_pkg::MUL_W'(py);
        end
        3'd4: begin
          mul_a = srfr_pkg::MUL_W'(rot_yx);
          mul_b = srfr_pkg::MUL_W'(px);
        end
        3'd5: begin
          mul_a = srfr_pkg::MUL_W'(rot_yy);
          mul_b = srfr_pkg::MUL_W'(py);
        end
        3'd6: begin
          mul_a = tx;
          mul_b = tx;
        end
        default: begin
          mul_a = ty;
          mul_b = ty;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_ANG;
        end
      end
      ST_ANG: begin
        state_next = ST_CORD;
      end
      ST_CORD: begin
        if (cord_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (sq_start) begin
          state_next = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fin_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      beam_index  <= '0;
      out_valid   <= 1'b0;
      mstep       <= '0;
      mphase      <= 1'b0;
      start_angle <= '0;
      angle_step  <= '0;
      rot_xx      <= 16'sd16384;
      rot_xy      <= '0;
      rot_yx      <= '0;
      rot_yy      <= 16'sd16384;
      shift_x     <= '0;
      shift_y     <= '0;
    end else begin
      state <= state_next;

      if (accept) begin
        if (scan_end || (beam_index == IW'(MAX_BEAMS - 1))) begin
          beam_index <= '0;
        end else begin
          beam_index <= beam_index + 1'b1;
        end
      end

      if (state == ST_MUL) begin
        mphase <= ~mphase;
        if (mphase) begin
          mstep <= mstep + 1'b1;
        end
      end else begin
        mphase <= 1'b0;
        mstep  <= '0;
      end

      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          srfr_pkg::CFG_START_ANGLE: start_angle <= cfg_data;
          srfr_pkg::CFG_ANGLE_STEP:  angle_step  <= cfg_data;
          srfr_pkg::CFG_ROT_XX:      rot_xx      <= cfg_data;
          srfr_pkg::CFG_ROT_XY:      rot_xy      <= cfg_data;
          srfr_pkg::CFG_ROT_YX:      rot_yx      <= cfg_data;
          srfr_pkg::CFG_ROT_YY:      rot_yy      <= cfg_data;
          srfr_pkg::CFG_SHIFT_X:     shift_x     <= cfg_data;
          srfr_pkg::CFG_SHIFT_Y:     shift_y     <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      range_q <= range_mm;
      last    <= scan_end;
    end

    if ((state == ST_MUL) && mphase) begin
      case (mstep)
        3'd0: gx <= prod[srfr_pkg::GAIN_SHR +: srfr_pkg::CORD_W];
        3'd1: gy <= prod[srfr_pkg::GAIN_SHR +: srfr_pkg::CORD_W];
        3'd2: acc <= prod[srfr_pkg::ACC_W-1:0];
        3'd3: tx <= acc_sum[srfr_pkg::ROT_SHR +: srfr_pkg::TX_W] + shift_term;
        3'd4: acc <= prod[srfr_pkg::ACC_W-1:0];
        3'd5: ty <= acc_sum[srfr_pkg::ROT_SHR +: srfr_pkg::TX_W] + shift_term;
        3'd6: sq <= prod;
        default: begin
        end
      endcase
    end

    if (fin_load) begin
      scan_end_out <= last;
      if (|rounded[srfr_pkg::ROOT_W:srfr_pkg::OUT_W+8]) begin
        frame_range <= '1;
      end else begin
        frame_range <= rounded[srfr_pkg::OUT_W+7:8];
      end
    end
  end

`ifndef SYNTHESIS
  a_out_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_FIN))
    else $error("result appeared without a finished computation");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_ANG))
    else $error("accepted beat did not start the angle step");

  a_cordic_done: assert property (@(posedge clk) disable iff (rst)
    cord_done |-> (state == ST_CORD))
    else $error("CORDIC finished outside its phase");

  a_sqrt_done: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == ST_SQRT))
    else $error("square root finished outside its phase");
`endif

endmodule
